### src/rmst_pkg.sv
`default_nettype none

package rmst_pkg;

    localparam int LEAVES      = 1024;
    localparam int NODES       = 2 * LEAVES;
    localparam int NODE_W      = $clog2(NODES);
    // node index with one spare bit: the exclusive right bound can reach NODES
    localparam int IDX_W       = NODE_W + 1;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_IN_W    = 11;

    localparam logic [IDX_IN_W-1:0]    LEAF_COUNT_RESET = 11'd1024;
    localparam logic [VALUE_WIDTH-1:0] KEY_SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] KEY_MIN  = '0;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef enum logic {
        STATUS_OK  = 1'b0,
        STATUS_BAD = 1'b1
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_Q_L,
        ST_Q_R,
        ST_Q_RD,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd                    cmd;
        logic [IDX_IN_W-1:0]     position;
        logic [VALUE_WIDTH-1:0]  key;
        logic [IDX_IN_W-1:0]     range_low;
        logic [IDX_IN_W-1:0]     range_high;
    } t_request;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  value;
        t_status                 status;
    } t_result;

    // Sign flip: unsigned order of keys equals signed order of values.
    // The same flip converts in both directions.
    function automatic logic [VALUE_WIDTH-1:0] key_flip(input logic [VALUE_WIDTH-1:0] v);
        key_flip = v ^ KEY_SIGN;
    endfunction

endpackage

`default_nettype wire

### src/rmst_node_ram.sv
`default_nettype none

module rmst_node_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### src/rmst_ctrl.sv
`default_nettype none

module rmst_ctrl
    import rmst_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire t_request            i_req,
    input  wire logic [IDX_IN_W-1:0] i_eff_count,
    input  wire logic                i_take,
    output logic                     o_idle,
    output logic                     o_done,
    output t_result                  o_res
);

    t_state                 r_state, n_state;
    logic [NODE_W-1:0]      r_node, n_node;
    logic [IDX_W-1:0]       r_l, n_l;
    logic [IDX_W-1:0]       r_r, n_r;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_pend_l, n_pend_l;
    t_result                r_res, n_res;

    logic                   ram_we;
    logic [NODE_W-1:0]      ram_addr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic [VALUE_WIDTH-1:0] cmp_max;
    logic [IDX_W-1:0]       leaf_idx;
    logic [NODE_W-1:0]      parent;
    logic                   upd_bad;
    logic                   qry_bad;

    rmst_node_ram #(
        .DEPTH (NODES),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // the one compare unit, shared by update and query walks
    assign cmp_max  = (ram_rdata > r_acc) ? ram_rdata : r_acc;
    assign leaf_idx = IDX_W'(LEAVES) + IDX_W'(i_req.position) - IDX_W'(1);
    assign parent   = r_node >> 1;
    assign upd_bad  = (i_req.position == '0) || (i_req.position > i_eff_count);
    assign qry_bad  = (i_req.range_low == '0) || (i_req.range_high > i_eff_count)
                   || (i_req.range_low > i_req.range_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_node  <= '0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
        end
        r_l      <= n_l;
        r_r      <= n_r;
        r_acc    <= n_acc;
        r_pend_l <= n_pend_l;
        r_res    <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_l       = r_l;
        n_r       = r_r;
        n_acc     = r_acc;
        n_pend_l  = r_pend_l;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = '0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_node;
                ram_wdata = KEY_MIN;
                n_node    = r_node + NODE_W'(1);
                if (r_node == NODE_W'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    if (i_req.cmd == CMD_UPDATE) begin
                        if (upd_bad) begin
                            n_res   = '{value: key_flip(KEY_MIN), status: STATUS_BAD};
                            n_state = ST_DONE;
                        end else begin
                            ram_we    = 1'b1;
                            ram_addr  = leaf_idx[NODE_W-1:0];
                            ram_wdata = i_req.key;
                            n_acc     = i_req.key;
                            n_node    = leaf_idx[NODE_W-1:0];
                            n_res     = '{value: key_flip(i_req.key), status: STATUS_OK};
                            n_state   = ST_UPD_RD;
                        end
                    end else begin
                        if (qry_bad) begin
                            n_res   = '{value: key_flip(KEY_MIN), status: STATUS_BAD};
                            n_state = ST_DONE;
                        end else begin
                            n_l     = IDX_W'(LEAVES) + IDX_W'(i_req.range_low) - IDX_W'(1);
                            n_r     = IDX_W'(LEAVES) + IDX_W'(i_req.range_high);
                            n_acc   = KEY_MIN;
                            n_state = ST_Q_L;
                        end
                    end
                end
            end
            ST_UPD_RD: begin
                // fetch the sibling of the node whose max is in r_acc
                ram_addr = r_node ^ NODE_W'(1);
                n_state  = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                ram_we    = 1'b1;
                ram_addr  = parent;
                ram_wdata = cmp_max;
                n_acc     = cmp_max;
                n_node    = parent;
                n_state   = (parent == NODE_W'(1)) ? ST_DONE : ST_UPD_RD;
            end
            ST_Q_L: begin
                if (r_l >= r_r) begin
                    n_res   = '{value: key_flip(r_acc), status: STATUS_OK};
                    n_state = ST_DONE;
                end else begin
                    n_pend_l = r_l[0];
                    if (r_l[0]) begin
                        ram_addr = r_l[NODE_W-1:0];
                        n_l      = r_l + IDX_W'(1);
                    end
                    n_state = ST_Q_R;
                end
            end
            ST_Q_R: begin
                if (r_pend_l) begin
                    n_acc = cmp_max;
                end
                if (r_r[0]) begin
                    ram_addr = NODE_W'(r_r - IDX_W'(1));
                    n_r      = r_r - IDX_W'(1);
                    n_state  = ST_Q_RD;
                end else begin
                    n_l     = r_l >> 1;
                    n_r     = r_r >> 1;
                    n_state = ST_Q_L;
                end
            end
            ST_Q_RD: begin
                n_acc   = cmp_max;
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = ST_Q_L;
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_done = (r_state == ST_DONE);
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == ST_IDLE)
        else $error("item started while sequencer busy");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_IDLE || r_state == ST_UPD_WR))
        else $error("node store written outside clear or update");

    a_upd_above_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD_RD || r_state == ST_UPD_WR) |-> r_node > NODE_W'(1))
        else $error("update walk reached past the root");

    a_query_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_L || r_state == ST_Q_R || r_state == ST_Q_RD) |-> r_l <= r_r)
        else $error("query bounds crossed");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_take) |=> (r_state == ST_DONE && $stable(r_res)))
        else $error("pending result lost before hand-off");
`endif

endmodule

`default_nettype wire

### src/range_max_segment_tree.sv
`default_nettype none

// Range-maximum segment tree over 1024 signed 32-bit leaves (one-based), kept
// in a single-port 2048-entry node RAM. After reset the block runs a clearing
// pass, writing the most negative value into every node; input is stalled
// meanwhile, config writes are still taken. Items are handled one at a time,
// the single RAM port and one max comparator setting the pace: an update does
// a leaf write, then a sibling read and a parent write per level; a query
// walks up over at most 11 levels, with a read on each bound plus the step up
// per level. A bad index or empty range returns with status 1 and the most
// negative value. The result sits in an output register, so the next item
// can be taken while it waits to be drained.
module range_max_segment_tree
    import rmst_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_cmd,
    input  wire logic        [IDX_IN_W-1:0]    i_position,
    input  wire logic signed [VALUE_WIDTH-1:0] i_new_value,
    input  wire logic        [IDX_IN_W-1:0]    i_range_low,
    input  wire logic        [IDX_IN_W-1:0]    i_range_high,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed      [VALUE_WIDTH-1:0] o_max_value,
    output logic                               o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic        [IDX_IN_W-1:0]    i_cfg_data
);

    logic [IDX_IN_W-1:0]    r_leaf_count;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_max;
    t_status                r_out_status;

    logic [IDX_IN_W-1:0]    eff_count;
    t_request               req;
    t_result                res;
    logic                   start;
    logic                   idle;
    logic                   done;
    logic                   take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_leaf_count <= i_cfg_data;
        end
    end

    assign eff_count = (32'(r_leaf_count) > 32'(LEAVES)) ? IDX_IN_W'(LEAVES) : r_leaf_count;

    assign req.cmd        = t_cmd'(i_cmd);
    assign req.position   = i_position;
    assign req.key        = key_flip(i_new_value);
    assign req.range_low  = i_range_low;
    assign req.range_high = i_range_high;

    assign o_in_stall = !idle;
    assign start      = i_in_valid && idle;
    // hand the result over when the output register is empty or draining
    assign take       = done && (!r_out_valid || !i_out_stall);

    rmst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_eff_count (eff_count),
        .i_take      (take),
        .o_idle      (idle),
        .o_done      (done),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out_max    <= res.value;
            r_out_status <= res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_value = r_out_max;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

### tb/range_max_segment_tree_tb.sv
`default_nettype none

module range_max_segment_tree_tb;
    import rmst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD   = 4;
    localparam int          RESET_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned HOLD_AFTER   = 250;   // results seen before the long hold-off
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned MAX_REPORTS  = 100;

    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        t_cmd                   cmd;
        logic [IDX_IN_W-1:0]    position;
        logic [VALUE_WIDTH-1:0] new_value;
        logic [IDX_IN_W-1:0]    range_low;
        logic [IDX_IN_W-1:0]    range_high;
    } t_tree_op;

    typedef struct packed {
        t_tree_op               op;
        logic                   fixed;
        logic [VALUE_WIDTH-1:0] fixed_value;
        t_status                fixed_status;
    } t_directed_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_pattern;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          in_valid     = 1'b0;
    t_cmd                          in_cmd       = CMD_UPDATE;
    logic        [IDX_IN_W-1:0]    in_position  = '0;
    logic signed [VALUE_WIDTH-1:0] in_new_value = '0;
    logic        [IDX_IN_W-1:0]    in_range_low = '0;
    logic        [IDX_IN_W-1:0]    in_range_high = '0;
    logic                          out_stall    = 1'b0;
    logic                          cfg_valid    = 1'b0;
    logic        [IDX_IN_W-1:0]    cfg_data     = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic signed [VALUE_WIDTH-1:0] o_max_value;
    logic                          o_status;
    logic                          o_cfg_ready;

    // predictor state: keys are values with the sign bit flipped
    logic [VALUE_WIDTH-1:0] tree_key [NODES];
    logic [IDX_IN_W-1:0]    model_leaf_count = LEAF_COUNT_RESET;
    t_result                expected_maxima [$];

    int unsigned cycle_count     = 0;
    int unsigned errors          = 0;
    int unsigned results_checked = 0;
    int unsigned n_updates       = 0;
    int unsigned n_queries       = 0;
    int unsigned n_rejected      = 0;
    int unsigned configs_written = 0;
    int unsigned burst_left      = 0;

    t_stall_pattern stall_pattern = STALL_NONE;
    int unsigned    pattern_left  = 0;
    int unsigned    hold_left     = 0;
    bit             hold_done     = 1'b0;
    bit             stall_next;
    t_result        exp_res;

    range_max_segment_tree dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (in_cmd),
        .i_position   (in_position),
        .i_new_value  (in_new_value),
        .i_range_low  (in_range_low),
        .i_range_high (in_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_max_value  (o_max_value),
        .o_status     (o_status),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned live_leaves();
        return (model_leaf_count > LEAVES) ? LEAVES : int'(model_leaf_count);
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] key_max(input logic [VALUE_WIDTH-1:0] a,
                                                       input logic [VALUE_WIDTH-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Applies one operation to the predicted tree and returns its result.
    function automatic t_result predict_tree_op(input t_tree_op op);
        t_result     res;
        int unsigned n;
        int unsigned k;
        int unsigned l;
        int unsigned r;
        logic [VALUE_WIDTH-1:0] acc;
        n = live_leaves();
        res.value  = VAL_MIN;
        res.status = STATUS_BAD;
        if (op.cmd == CMD_UPDATE) begin
            if (op.position == 0 || op.position > n)
                return res;
            k = LEAVES + op.position - 1;
            tree_key[k] = op.new_value ^ KEY_SIGN;
            while (k > 1) begin
                k = k >> 1;
                tree_key[k] = key_max(tree_key[2 * k], tree_key[2 * k + 1]);
            end
            res.value = op.new_value;
        end else begin
            if (op.range_low == 0 || op.range_high > n || op.range_low > op.range_high)
                return res;
            l = LEAVES + op.range_low - 1;
            r = LEAVES + op.range_high;
            acc = KEY_MIN;
            // half-open node range, walked bottom-up
            while (l < r) begin
                if (l[0]) begin
                    acc = key_max(acc, tree_key[l]);
                    l++;
                end
                if (r[0]) begin
                    r--;
                    acc = key_max(acc, tree_key[r]);
                end
                l = l >> 1;
                r = r >> 1;
            end
            res.value = acc ^ KEY_SIGN;
        end
        res.status = STATUS_OK;
        return res;
    endfunction

    function automatic logic [IDX_IN_W-1:0] pick_leaf(input int unsigned n);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return IDX_IN_W'($urandom_range(1, (n < 32) ? n : 32));  // hot window
        else if (sel == 3)
            return IDX_IN_W'(n);
        else if (sel == 4)
            return IDX_IN_W'(1);
        return IDX_IN_W'($urandom_range(1, n));
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_tree_op draw_tree_op(input int unsigned n);
        t_tree_op    op;
        int unsigned sel;
        logic [IDX_IN_W-1:0] a;
        logic [IDX_IN_W-1:0] b;
        op.cmd        = t_cmd'($urandom_range(0, 1));
        op.position   = IDX_IN_W'($urandom_range(0, 2047));
        op.new_value  = pick_value();
        op.range_low  = IDX_IN_W'($urandom_range(0, 2047));
        op.range_high = IDX_IN_W'($urandom_range(0, 2047));
        sel = $urandom_range(0, 99);
        if (n == 0 || sel < 8)
            return op;
        if (sel < 50) begin
            op.cmd      = CMD_UPDATE;
            op.position = pick_leaf(n);
        end else begin
            op.cmd = CMD_QUERY;
            a = pick_leaf(n);
            if ($urandom_range(0, 1)) begin
                b = IDX_IN_W'(a + $urandom_range(0, 15));
                if (b > n)
                    b = IDX_IN_W'(n);
            end else begin
                b = pick_leaf(n);
            end
            // a few reversed ranges
            if (sel >= 96) begin
                op.range_low  = (a > b) ? a : b;
                op.range_high = (a > b) ? b : a;
            end else begin
                op.range_low  = (a > b) ? b : a;
                op.range_high = (a > b) ? a : b;
            end
        end
        return op;
    endfunction

    task automatic offer_op(input t_tree_op op, input bit use_fixed, input t_result fixed_res);
        t_result     predicted;
        int unsigned gap;
        in_valid      <= 1'b1;
        in_cmd        <= op.cmd;
        in_position   <= op.position;
        in_new_value  <= op.new_value;
        in_range_low  <= op.range_low;
        in_range_high <= op.range_high;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = predict_tree_op(op);
        expected_maxima.push_back(use_fixed ? fixed_res : predicted);
        if (op.cmd == CMD_UPDATE)
            n_updates++;
        else
            n_queries++;
        if (predicted.status == STATUS_BAD)
            n_rejected++;
        // bursts of back-to-back transactions separated by random gaps
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(1, 15);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_idle();
        int unsigned waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_maxima.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_leaf_count(input logic [IDX_IN_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        model_leaf_count = count;
        configs_written++;
    endtask

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                results_checked++;
                if (expected_maxima.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, got %0d status %0d",
                                 $time, o_max_value, o_status);
                end else begin
                    exp_res = expected_maxima.pop_front();
                    if (o_max_value !== exp_res.value) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: max_value mismatch: expected %0d, got %0d",
                                     $time, $signed(exp_res.value), o_max_value);
                    end
                    if (o_status !== exp_res.status) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: status mismatch: expected %0d, got %0d",
                                     $time, exp_res.status, o_status);
                    end
                end
            end
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    stall_pattern = t_stall_pattern'($urandom_range(0, 3));
                    pattern_left  = $urandom_range(20, 200);
                end else begin
                    pattern_left--;
                end
                case (stall_pattern)
                    STALL_NONE:     stall_next = 1'b0;
                    STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: stall_next = (cycle_count % 3 == 0);
                    default:        stall_next = 1'b0;
                endcase
            end
            out_stall <= stall_next;
        end
    end

    initial begin
        t_directed_row       directed_rows [23];
        logic [IDX_IN_W-1:0] phase_count_value [7];
        int unsigned         phase_items [7];
        t_result             fixed_res;
        t_tree_op            op;

        foreach (tree_key[i])
            tree_key[i] = KEY_MIN;

        // op: cmd, position, new_value, range_low, range_high; then a fixed result if known
        directed_rows = '{
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd1,    11'd1024}, 1'b1, VAL_MIN, STATUS_OK},
            '{'{CMD_UPDATE, 11'd0,    32'h1234,     11'd0,    11'd0},    1'b1, VAL_MIN, STATUS_BAD},
            '{'{CMD_UPDATE, 11'd1025, 32'd9,        11'd3,    11'd3},    1'b1, VAL_MIN, STATUS_BAD},
            '{'{CMD_UPDATE, 11'd2047, 32'hFFFF_FFFF, 11'd2047, 11'd2047}, 1'b1, VAL_MIN, STATUS_BAD},
            '{'{CMD_UPDATE, 11'd1,    VAL_MAX,      11'd0,    11'd0},    1'b1, VAL_MAX, STATUS_OK},
            '{'{CMD_UPDATE, 11'd1024, VAL_MIN,      11'd1,    11'd2},    1'b1, VAL_MIN, STATUS_OK},
            '{'{CMD_UPDATE, 11'd512,  32'd5,        11'd0,    11'd0},    1'b1, 32'd5,   STATUS_OK},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd1,    11'd1},    1'b1, VAL_MAX, STATUS_OK},
            '{'{CMD_QUERY,  11'd7,    32'd0,        11'd0,    11'd5},    1'b1, VAL_MIN, STATUS_BAD},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd5,    11'd4},    1'b1, VAL_MIN, STATUS_BAD},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd1,    11'd1025}, 1'b1, VAL_MIN, STATUS_BAD},
            '{'{CMD_QUERY,  11'd2047, VAL_MAX,      11'd2047, 11'd2047}, 1'b1, VAL_MIN, STATUS_BAD},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd1024, 11'd1024}, 1'b1, VAL_MIN, STATUS_OK},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd2,    11'd1024}, 1'b0, '0,      STATUS_OK},
            '{'{CMD_UPDATE, 11'd700,  -32'sd7,      11'd0,    11'd0},    1'b1, -32'sd7, STATUS_OK},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd513,  11'd1024}, 1'b0, '0,      STATUS_OK},
            '{'{CMD_UPDATE, 11'd1,    VAL_MIN,      11'd0,    11'd0},    1'b0, '0,      STATUS_OK},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd1,    11'd511},  1'b0, '0,      STATUS_OK},
            '{'{CMD_UPDATE, 11'd1023, 32'h5555_5555, 11'd0,   11'd0},    1'b0, '0,      STATUS_OK},
            '{'{CMD_UPDATE, 11'd2,    32'hAAAA_AAAA, 11'd0,   11'd0},    1'b0, '0,      STATUS_OK},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd1,    11'd1024}, 1'b0, '0,      STATUS_OK},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd512,  11'd512},  1'b0, '0,      STATUS_OK},
            '{'{CMD_QUERY,  11'd0,    32'd0,        11'd1,    11'd2047}, 1'b1, VAL_MIN, STATUS_BAD}
        };

        // above LEAVES, one leaf, none, full, small, random, near full
        phase_count_value = '{11'd2047, 11'd1, 11'd0, 11'd1024, 11'd13,
                              11'($urandom_range(2, 1023)), 11'd1000};
        phase_items = '{70, 35, 15, 170, 60, 110, 90};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part runs on the reset leaf count
        foreach (directed_rows[i]) begin
            fixed_res.value  = directed_rows[i].fixed_value;
            fixed_res.status = directed_rows[i].fixed_status;
            offer_op(directed_rows[i].op, directed_rows[i].fixed, fixed_res);
        end
        wait_for_idle();

        foreach (phase_items[p]) begin
            write_leaf_count(phase_count_value[p]);
            repeat (phase_items[p]) begin
                op = draw_tree_op(live_leaves());
                offer_op(op, 1'b0, fixed_res);
            end
            wait_for_idle();
        end

        repeat (60) @(posedge i_clk);
        if (expected_maxima.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived: expected %0d, got none",
                     $time, expected_maxima.size(), $signed(expected_maxima[0].value));
        end

        $display("Covered %0d updates and %0d queries (%0d with a bad index or range)",
                 n_updates, n_queries, n_rejected);
        $display("over %0d leaf_count settings; %0d results checked, %0d mismatches.",
                 configs_written + 1, results_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### range_max_segment_tree.f
src/rmst_pkg.sv
src/rmst_node_ram.sv
src/rmst_ctrl.sv
src/range_max_segment_tree.sv
tb/range_max_segment_tree_tb.sv
